// File: hw/rtl/swra_pkg.sv
// ----------------------------------------------------------------------------
// swra_pkg
// Shared types and constants of the sliding-window receiver with cumulative
// ack: register map, register reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package swra_pkg;

    typedef logic [0:0] reg_idx_t;

    localparam reg_idx_t REG_TOTAL_COUNT = 1'b0;
    localparam reg_idx_t REG_WINDOW_SIZE = 1'b1;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [15:0] TOTAL_COUNT_RESET = 16'd20000;
    localparam logic [5:0]  WINDOW_SIZE_RESET = 6'd1;

    typedef struct packed {
        logic [15:0] total_count;
        logic [5:0]  window_size;
        logic        restart;
    } cfg_t;

endpackage

// File: hw/rtl/swra_cfg.sv
// ----------------------------------------------------------------------------
// swra_cfg
// APB-style register block: holds total_count and window_size and raises a
// restart strobe on every register write.
// ----------------------------------------------------------------------------
module swra_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swra_pkg::PADDR_W-1:0]    paddr,
    input  logic [swra_pkg::PDATA_W-1:0]    pwdata,
    output logic [swra_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    output swra_pkg::cfg_t                  cfg
);
    import swra_pkg::*;

    logic [15:0] total_count_reg;
    logic [5:0]  window_size_reg;
    logic        wr_en;
    reg_idx_t    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_count_reg <= TOTAL_COUNT_RESET;
            window_size_reg <= WINDOW_SIZE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TOTAL_COUNT: total_count_reg <= pwdata[15:0];
                REG_WINDOW_SIZE: window_size_reg <= pwdata[5:0];
                default:         total_count_reg <= total_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TOTAL_COUNT: prdata = {{(PDATA_W-16){1'b0}}, total_count_reg};
            REG_WINDOW_SIZE: prdata = {{(PDATA_W-6){1'b0}}, window_size_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.total_count = total_count_reg;
    assign cfg.window_size = window_size_reg;
    assign cfg.restart     = wr_en;

endmodule

// File: hw/rtl/swra_core.sv
// ----------------------------------------------------------------------------
// swra_core
// Receive sequencer: bitmap memory with clearing pass, mark step and a walk
// over consecutive marked entries through one shared step unit, and a deliver step.
// ----------------------------------------------------------------------------
module swra_core #(
    parameter int unsigned SEQ_SPACE  = 32768,
    parameter int unsigned WINDOW_MAX = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  swra_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [14:0]         seq,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  ack_seq,
    output logic                done_res
);
    import swra_pkg::*;

    localparam int unsigned IDX_W = $clog2(SEQ_SPACE);
    localparam int unsigned SPW   = $clog2(SEQ_SPACE + 1);
    localparam int unsigned CW    = ((SPW > 16) ? SPW : 16) + 1;
    localparam int unsigned WCW   = $clog2(WINDOW_MAX + 1);
    localparam int unsigned WW    = ((WCW > 6) ? WCW : 6) + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK,
        ST_WALK,
        ST_DELIVER
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    clr_cnt_reg;
    logic [14:0]         seq_reg;
    logic [CW-1:0]       next_reg;
    logic [CW-1:0]       wend_reg;
    logic [WW-1:0]       cnt_reg;
    logic [15:0]         pend_ack_reg;
    logic                pend_done_reg;
    logic                out_valid_reg;
    logic [15:0]         ack_reg;
    logic                done_reg;

    logic                mem [SEQ_SPACE];
    logic                rd_data_reg;

    logic [CW-1:0]       t_eff;
    logic [WW-1:0]       w_eff;
    logic [CW-1:0]       s_ext;
    logic [CW-1:0]       next_inc;
    logic [WW-1:0]       cnt_inc;
    logic                can_go;
    logic                step_ok;
    logic [CW-1:0]       fin_next;
    logic [WW-1:0]       fin_cnt;
    logic [CW-1:0]       wend_sum;
    logic [CW-1:0]       wend_fin;
    logic [CW-1:0]       wend_init;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic                wr_data;
    logic [IDX_W-1:0]    rd_addr;

    // effective register values
    assign t_eff = (CW'(cfg.total_count) > CW'(SEQ_SPACE)) ? CW'(SEQ_SPACE)
                                                           : CW'(cfg.total_count);
    assign w_eff = (WW'(cfg.window_size) > WW'(WINDOW_MAX)) ? WW'(WINDOW_MAX)
                                                            : WW'(cfg.window_size);
    assign wend_init = (CW'(w_eff) > t_eff) ? t_eff : CW'(w_eff);

    // shared step unit
    assign s_ext    = CW'(seq_reg);
    assign next_inc = next_reg + CW'(1);
    assign cnt_inc  = cnt_reg + WW'(1);
    assign can_go   = (cnt_inc < w_eff) && (next_inc < t_eff);
    assign step_ok  = (state_reg == ST_MARK) || rd_data_reg;
    assign fin_next = step_ok ? next_inc : next_reg;
    assign fin_cnt  = step_ok ? cnt_inc : cnt_reg;
    assign wend_sum = wend_reg + CW'(fin_cnt);
    assign wend_fin = (wend_sum > t_eff) ? t_eff : wend_sum;

    // bitmap ports
    assign rd_addr = next_inc[IDX_W-1:0];
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = s_ext[IDX_W-1:0];
        wr_data = 1'b1;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = 1'b0;
        end
        else if (state_reg == ST_MARK)
        begin
            wr_en = (next_reg < t_eff) && (s_ext < t_eff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            next_reg      <= '0;
            wend_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != ST_DELIVER))
            begin
                out_valid_reg <= 1'b0;
            end
            // any register write restarts the transfer
            if (cfg.restart)
            begin
                state_reg   <= ST_CLEAR;
                clr_cnt_reg <= '0;
                next_reg    <= '0;
            end
            else
            begin
                unique case (state_reg)
                    ST_CLEAR:
                    begin
                        clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
                        if (clr_cnt_reg == IDX_W'(SEQ_SPACE - 1))
                        begin
                            wend_reg  <= wend_init;
                            state_reg <= ST_IDLE;
                        end
                    end
                    ST_IDLE:
                    begin
                        if (in_valid)
                        begin
                            seq_reg   <= seq;
                            cnt_reg   <= '0;
                            state_reg <= ST_MARK;
                        end
                    end
                    ST_MARK:
                    begin
                        if (next_reg >= t_eff)
                        begin
                            pend_ack_reg  <= 16'(t_eff - CW'(1));
                            pend_done_reg <= 1'b1;
                            state_reg     <= ST_DELIVER;
                        end
                        else if (s_ext >= next_reg && s_ext >= wend_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (s_ext == next_reg)
                        begin
                            if (can_go)
                            begin
                                next_reg  <= next_inc;
                                cnt_reg   <= cnt_inc;
                                state_reg <= ST_WALK;
                            end
                            else
                            begin
                                next_reg      <= fin_next;
                                wend_reg      <= wend_fin;
                                pend_ack_reg  <= 16'(fin_next - CW'(1));
                                pend_done_reg <= (fin_next >= t_eff);
                                state_reg     <= ST_DELIVER;
                            end
                        end
                        else
                        begin
                            pend_ack_reg  <= 16'(next_reg - CW'(1));
                            pend_done_reg <= 1'b0;
                            state_reg     <= ST_DELIVER;
                        end
                    end
                    ST_WALK:
                    begin
                        if (rd_data_reg && can_go)
                        begin
                            next_reg <= next_inc;
                            cnt_reg  <= cnt_inc;
                        end
                        else
                        begin
                            next_reg      <= fin_next;
                            wend_reg      <= wend_fin;
                            pend_ack_reg  <= 16'(fin_next - CW'(1));
                            pend_done_reg <= (fin_next >= t_eff);
                            state_reg     <= ST_DELIVER;
                        end
                    end
                    ST_DELIVER:
                    begin
                        if (!out_valid_reg || out_ready)
                        begin
                            out_valid_reg <= 1'b1;
                            ack_reg       <= pend_ack_reg;
                            done_reg      <= pend_done_reg;
                            state_reg     <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_CLEAR;
                    end
                endcase
            end
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign ack_seq   = $signed(ack_reg);
    assign done_res  = done_reg;

endmodule

// File: hw/rtl/sliding_window_receiver_ack_top.sv
// ----------------------------------------------------------------------------
// sliding_window_receiver_ack_top
// Sliding-window receiver with cumulative ack: marks arriving sequence
// numbers in a bitmap and answers with the highest in-order number received.
//
// Usage
//   input channel : in_valid / in_ready / seq, one sequence number a transfer
//   output channel: out_valid / out_ready / ack_seq / done_res, zero or one
//                   result per input transfer; numbers at or past the window
//                   end give no result
//   config port   : APB-style, total_count at 0x0, window_size at 0x4
//   timing        : an input transfer passes the mark step, then the walk
//                   over the bitmap entries read after an in-order number,
//                   then the deliver step, which raises out_valid; in_ready
//                   returns as out_valid rises, or after the mark step if
//                   no result; no new input before the last is through
//   reset         : after rst_n and after every register write the bitmap
//                   is cleared one entry a cycle, all SEQ_SPACE entries,
//                   with in_ready low
//   stall         : a result waits in the output register; the next input
//                   is taken meanwhile and its result held until out_ready
// ----------------------------------------------------------------------------
module sliding_window_receiver_ack_top #(
    parameter int unsigned SEQ_SPACE  = 32768,
    parameter int unsigned WINDOW_MAX = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swra_pkg::PADDR_W-1:0]    paddr,
    input  logic [swra_pkg::PDATA_W-1:0]    pwdata,
    output logic [swra_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [14:0]                     seq,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [15:0]              ack_seq,
    output logic                            done_res
);
    import swra_pkg::*;

    cfg_t cfg;

    swra_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swra_core #(
        .SEQ_SPACE  (SEQ_SPACE),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .seq       (seq),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ack_seq   (ack_seq),
        .done_res  (done_res)
    );

endmodule
